@@ src/lsct_pkg.sv @@
// Shared types, widths and register codes for the local simplex cover test.
package lsct_pkg;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int LIMIT_W    = 34;
  localparam int CMP_W      = (CROSS_W > LIMIT_W) ? CROSS_W : LIMIT_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT = CFG_IDX_W'(1);

  localparam logic MODE_DIAMETER = 1'b0;
  localparam logic MODE_AREA     = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic [PROD_W-1:0]         sq_t;

  typedef struct packed {
    coord_t vert_a_x;
    coord_t vert_a_y;
    coord_t vert_b_x;
    coord_t vert_b_y;
    coord_t vert_c_x;
    coord_t vert_c_y;
    coord_t query_x;
    coord_t query_y;
  } in_t;

  typedef struct packed {
    logic covered;
    logic covered_local;
  } out_t;

  typedef struct packed {
    prod_t d1_p;
    prod_t d1_n;
    prod_t d2_p;
    prod_t d2_n;
    prod_t d3_p;
    prod_t d3_n;
    prod_t ta_p;
    prod_t ta_n;
    sq_t   ab_x;
    sq_t   ab_y;
    sq_t   bc_x;
    sq_t   bc_y;
    sq_t   ac_x;
    sq_t   ac_y;
    logic  on_vertex;
    logic  in_box;
  } geom_t;

  function automatic diff_t sub_c(coord_t u, coord_t v);
    diff_t r;
    r = diff_t'(u) - diff_t'(v);
    return r;
  endfunction

endpackage

@@ src/lsct_geom.sv @@
// Product stage: coordinate differences, cross and square products, vertex and box flags.
module lsct_geom (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         req_valid,
  input  lsct_pkg::in_t req,
  output logic         geom_valid,
  output lsct_pkg::geom_t geom
);
  import lsct_pkg::*;

  diff_t bax, bay, cax, cay, cbx, cby, acx, acy;
  diff_t qax, qay, qbx, qby, qcx, qcy;
  prod_t ab_x_s, ab_y_s, bc_x_s, bc_y_s, ac_x_s, ac_y_s;
  geom_t geom_nxt;
  geom_t geom_r;
  logic  valid_r;

  always_comb begin
    bax = sub_c(req.vert_b_x, req.vert_a_x);
    bay = sub_c(req.vert_b_y, req.vert_a_y);
    cax = sub_c(req.vert_c_x, req.vert_a_x);
    cay = sub_c(req.vert_c_y, req.vert_a_y);
    cbx = sub_c(req.vert_c_x, req.vert_b_x);
    cby = sub_c(req.vert_c_y, req.vert_b_y);
    acx = sub_c(req.vert_a_x, req.vert_c_x);
    acy = sub_c(req.vert_a_y, req.vert_c_y);
    qax = sub_c(req.query_x, req.vert_a_x);
    qay = sub_c(req.query_y, req.vert_a_y);
    qbx = sub_c(req.query_x, req.vert_b_x);
    qby = sub_c(req.query_y, req.vert_b_y);
    qcx = sub_c(req.query_x, req.vert_c_x);
    qcy = sub_c(req.query_y, req.vert_c_y);

    ab_x_s = bax * bax;
    ab_y_s = bay * bay;
    bc_x_s = cbx * cbx;
    bc_y_s = cby * cby;
    ac_x_s = acx * acx;
    ac_y_s = acy * acy;

    geom_nxt.d1_p = bax * qay;
    geom_nxt.d1_n = bay * qax;
    geom_nxt.d2_p = cbx * qby;
    geom_nxt.d2_n = cby * qbx;
    geom_nxt.d3_p = acx * qcy;
    geom_nxt.d3_n = acy * qcx;
    geom_nxt.ta_p = bax * cay;
    geom_nxt.ta_n = bay * cax;
    geom_nxt.ab_x = sq_t'(ab_x_s);
    geom_nxt.ab_y = sq_t'(ab_y_s);
    geom_nxt.bc_x = sq_t'(bc_x_s);
    geom_nxt.bc_y = sq_t'(bc_y_s);
    geom_nxt.ac_x = sq_t'(ac_x_s);
    geom_nxt.ac_y = sq_t'(ac_y_s);

    geom_nxt.on_vertex =
        (req.query_x == req.vert_a_x && req.query_y == req.vert_a_y) ||
        (req.query_x == req.vert_b_x && req.query_y == req.vert_b_y) ||
        (req.query_x == req.vert_c_x && req.query_y == req.vert_c_y);
    geom_nxt.in_box =
        (req.query_x >= req.vert_a_x || req.query_x >= req.vert_b_x ||
         req.query_x >= req.vert_c_x) &&
        (req.query_x <= req.vert_a_x || req.query_x <= req.vert_b_x ||
         req.query_x <= req.vert_c_x) &&
        (req.query_y >= req.vert_a_y || req.query_y >= req.vert_b_y ||
         req.query_y >= req.vert_c_y) &&
        (req.query_y <= req.vert_a_y || req.query_y <= req.vert_b_y ||
         req.query_y <= req.vert_c_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  assign geom_valid = valid_r;
  assign geom       = geom_r;

endmodule

@@ src/lsct_decide.sv @@
// Decision stage: cross-product signs, degenerate case and locality compare.
module lsct_decide (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          geom_valid,
  input  lsct_pkg::geom_t               geom,
  input  logic                          size_mode,
  input  logic [lsct_pkg::LIMIT_W-1:0]  size_limit,
  output logic                          res_valid,
  output lsct_pkg::out_t                res
);
  import lsct_pkg::*;

  prod_t  d1p, d1n, d2p, d2n, d3p, d3n, tap, tan_s;
  cross_t d1, d2, d3, ta;
  logic [CROSS_W-1:0] ta_mag;
  logic [PROD_W-1:0]  sq_ab, sq_bc, sq_ac;
  logic [CMP_W-1:0]   limit_w;
  logic neg, pos, covered, local_ok;
  out_t res_nxt;
  out_t res_r;
  logic valid_r;

  always_comb begin
    d1p = geom.d1_p;
    d1n = geom.d1_n;
    d2p = geom.d2_p;
    d2n = geom.d2_n;
    d3p = geom.d3_p;
    d3n = geom.d3_n;
    tap = geom.ta_p;
    tan_s = geom.ta_n;
    d1 = cross_t'(d1p) - cross_t'(d1n);
    d2 = cross_t'(d2p) - cross_t'(d2n);
    d3 = cross_t'(d3p) - cross_t'(d3n);
    ta = cross_t'(tap) - cross_t'(tan_s);
    ta_mag = ta[CROSS_W-1] ? CROSS_W'(-ta) : CROSS_W'(ta);

    neg = d1[CROSS_W-1] || d2[CROSS_W-1] || d3[CROSS_W-1];
    pos = (!d1[CROSS_W-1] && d1 != '0) || (!d2[CROSS_W-1] && d2 != '0) ||
          (!d3[CROSS_W-1] && d3 != '0);

    if (geom.on_vertex) begin
      covered = 1'b1;
    end else if (ta == '0) begin
      covered = d1 == '0 && d2 == '0 && d3 == '0 && geom.in_box;
    end else begin
      covered = !(neg && pos);
    end

    sq_ab   = geom.ab_x + geom.ab_y;
    sq_bc   = geom.bc_x + geom.bc_y;
    sq_ac   = geom.ac_x + geom.ac_y;
    limit_w = CMP_W'(size_limit);
    if (size_mode == MODE_AREA) begin
      local_ok = CMP_W'(ta_mag) <= limit_w;
    end else begin
      local_ok = CMP_W'(sq_ab) <= limit_w && CMP_W'(sq_bc) <= limit_w &&
                 CMP_W'(sq_ac) <= limit_w;
    end

    res_nxt.covered       = covered;
    res_nxt.covered_local = covered && local_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= geom_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = valid_r;
  assign res       = res_r;

  a_local_implies_covered: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (!res_r.covered_local || res_r.covered))
    else $error("covered_local without covered");

  a_vertex_covered: assert property (@(posedge clk) disable iff (!rst_n)
    (geom_valid && geom.on_vertex) |=> res_r.covered)
    else $error("query on vertex not covered");

  a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    geom_valid |=> valid_r)
    else $error("request lost in decision stage");

endmodule

@@ src/local_simplex_cover_test.sv @@
// Top level of the local simplex cover test: request register, config registers, stages.
// A request passes the request, product and decision registers before its strobe.
// Throughput: one request per cycle; busy is high only while rst_n is low.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset: pipeline valids clear, size_mode and size_limit return to 0.
module local_simplex_cover_test (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  lsct_pkg::in_t                    in_req,
  output logic                             out_valid,
  output lsct_pkg::out_t                   out_res,
  input  logic                             cfg_we,
  input  logic [lsct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsct_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lsct_pkg::*;

  logic               accept;
  in_t                req_r;
  logic               req_valid_r;
  logic               size_mode_r;
  logic [LIMIT_W-1:0] size_limit_r;
  logic               geom_valid;
  geom_t              geom;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r  <= 1'b0;
      size_mode_r  <= 1'b0;
      size_limit_r <= '0;
    end else begin
      req_valid_r <= accept;
      if (cfg_we && cfg_index == REG_SIZE_MODE) begin
        size_mode_r <= cfg_wdata[0];
      end
      if (cfg_we && cfg_index == REG_SIZE_LIMIT) begin
        size_limit_r <= cfg_wdata[LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
  end

  lsct_geom u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid_r),
    .req        (req_r),
    .geom_valid (geom_valid),
    .geom       (geom)
  );

  lsct_decide u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom_valid (geom_valid),
    .geom       (geom),
    .size_mode  (size_mode_r),
    .size_limit (size_limit_r),
    .res_valid  (out_valid),
    .res        (out_res)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 3))
    else $error("result strobe without matching request");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("accepted request produced no result");

endmodule
